FILE: hdl/ksw_pkg.sv
package ksw_pkg;

    // Window geometry
    localparam int WIN_DEPTH = 16;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int DISP_W    = 4;

    localparam logic [DISP_W-1:0] DISP_RESET = DISP_W'(2);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [FILL_W-1:0]        fill_t;

    // Running minimum handed from cell to cell during a scan
    typedef struct packed {
        data_t val;
        idx_t  idx;
    } pass_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic  load;   // write din into the cell addressed by sel
        logic  scan;   // cell addressed by sel folds itself into the minimum
        logic  shift;  // remove the selected minimum, front moves into its slot
        idx_t  sel;
        idx_t  best;
        data_t din;
        data_t front;
    } cell_ctrl_t;

endpackage

FILE: hdl/k_sorted_window_sorter_top.sv
// Sorts a stream in which every word lies at most K places from its sorted
// place (K = displacement, 0..15, reset 2). Words enter a window held in a
// row of 16 cells; once the window holds K+1 words the smallest is emitted
// (earliest on ties), the front word takes its slot and the rest move one
// place forward. A word with tlast drains the window and the final result
// carries tlast. Each result takes a scan over span = min(fill, K+1) cells,
// the running minimum walking through them one cell per cycle, then an emit
// step that waits for the output to be free; a new word is taken only once
// the sequencer is back in idle. Write displacement only
// while the block is idle.
module k_sorted_window_sorter_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: [3:0] displacement
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast    // final_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int N = ksw_pkg::WIN_DEPTH;

    logic [1:0]                  state_reg, state_next;
    logic [ksw_pkg::DISP_W-1:0]  disp_reg, disp_next;
    ksw_pkg::fill_t              fill_reg, fill_next;
    ksw_pkg::fill_t              span_reg, span_next;
    ksw_pkg::idx_t               cnt_reg, cnt_next;
    logic                        last_reg, last_next;
    logic                        ovld_reg, ovld_next;
    ksw_pkg::data_t              odata_reg, odata_next;
    logic                        olast_reg, olast_next;

    ksw_pkg::cell_ctrl_t         ctrl;
    ksw_pkg::data_t              entry_q [N];
    ksw_pkg::pass_t              pass_q  [N];
    ksw_pkg::pass_t              pass_d  [N];
    ksw_pkg::data_t              nxt_d   [N];

    ksw_pkg::fill_t              limit;
    ksw_pkg::idx_t               span_last;
    ksw_pkg::pass_t              best;
    logic                        out_free;
    logic                        in_acc;
    logic                        need;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !ovld_reg || m_tready;

    assign limit     = ksw_pkg::fill_t'(disp_reg) + ksw_pkg::fill_t'(1);
    assign span_last = ksw_pkg::idx_t'(span_reg - ksw_pkg::fill_t'(1));
    assign best      = pass_q[span_last];
    assign need      = last_reg ? (fill_reg != '0)
                                : ((fill_reg != '0) && (fill_reg >= limit));

    // Chain of cells: minimum walks forward, entries shift toward the front
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign pass_d[g] = '{val: entry_q[0], idx: '0};
        end
        else
        begin : g_body
            assign pass_d[g] = pass_q[g-1];
        end
        if (g == N - 1)
        begin : g_tail
            assign nxt_d[g] = entry_q[g];
        end
        else
        begin : g_mid
            assign nxt_d[g] = entry_q[g+1];
        end

        ksw_cell u_cell
        (
            .clk        (clk),
            .cell_idx   (ksw_pkg::idx_t'(g)),
            .ctrl       (ctrl),
            .next_entry (nxt_d[g]),
            .pass_in    (pass_d[g]),
            .entry      (entry_q[g]),
            .pass_out   (pass_q[g])
        );
    end

    // Sequencer: accept, check, scan, emit
    always_comb
    begin
        state_next = state_reg;
        disp_next  = disp_reg;
        fill_next  = fill_reg;
        span_next  = span_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        ovld_next  = ovld_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;

        ctrl       = '0;
        ctrl.din   = s_tdata;
        ctrl.front = entry_q[0];
        ctrl.best  = best.idx;

        if (cfg_valid && cfg_ready)
        begin
            disp_next = cfg_data;
        end

        // Drop the output word once taken
        if (ovld_reg && m_tready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    last_next = s_tlast;
                    if (fill_reg < ksw_pkg::fill_t'(N))
                    begin
                        ctrl.load = 1'b1;
                        ctrl.sel  = ksw_pkg::idx_t'(fill_reg);
                        fill_next = fill_reg + ksw_pkg::fill_t'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (need)
                begin
                    span_next  = (fill_reg < limit) ? fill_reg : limit;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                ctrl.sel  = cnt_reg;
                if (cnt_reg == span_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + ksw_pkg::idx_t'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    odata_next = best.val;
                    olast_next = last_reg && (fill_reg == ksw_pkg::fill_t'(1));
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - ksw_pkg::fill_t'(1);
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            disp_reg  <= ksw_pkg::DISP_RESET;
            fill_reg  <= '0;
            span_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            disp_reg  <= disp_next;
            fill_reg  <= fill_next;
            span_reg  <= span_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Output payload holds until taken
    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: hdl/ksw_cell.sv
module ksw_cell
(
    input  logic               clk,
    input  ksw_pkg::idx_t      cell_idx,
    input  ksw_pkg::cell_ctrl_t ctrl,
    input  ksw_pkg::data_t     next_entry,
    input  ksw_pkg::pass_t     pass_in,
    output ksw_pkg::data_t     entry,
    output ksw_pkg::pass_t     pass_out
);

    ksw_pkg::data_t entry_reg;
    ksw_pkg::data_t entry_next;
    ksw_pkg::pass_t pass_reg;
    ksw_pkg::pass_t pass_next;
    logic           take_front;

    // Front entry lands one place before the removed minimum
    assign take_front = (ctrl.best != '0) && (cell_idx == ctrl.best - ksw_pkg::idx_t'(1));

    // Load, shift toward the front, or hold
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load && (ctrl.sel == cell_idx))
        begin
            entry_next = ctrl.din;
        end
        else if (ctrl.shift)
        begin
            entry_next = take_front ? ctrl.front : next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Fold own entry into the running minimum; earlier entry wins ties
    always_comb
    begin
        pass_next = pass_reg;
        if (ctrl.scan && (ctrl.sel == cell_idx))
        begin
            if (entry_reg < pass_in.val)
            begin
                pass_next.val = entry_reg;
                pass_next.idx = cell_idx;
            end
            else
            begin
                pass_next = pass_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pass_reg  <= pass_next;
    end

    assign entry    = entry_reg;
    assign pass_out = pass_reg;

endmodule

FILE: verif/ksw_sort_checker.sv
module ksw_sort_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        ksw_pkg::data_t value;
        logic           final_word;
    } sorted_word_t;

    // Shadow of the window and the displacement register
    ksw_pkg::data_t             window_q [ksw_pkg::WIN_DEPTH];
    int                         fill_cnt;
    logic [ksw_pkg::DISP_W-1:0] disp_q;

    sorted_word_t      expected_words [$];
    sorted_word_t      want;

    function automatic int search_limit();
        int lim = int'(disp_q) + 1;
        return (lim > ksw_pkg::WIN_DEPTH) ? ksw_pkg::WIN_DEPTH : lim;
    endfunction

    // Remove the smallest of the searched entries; the front word fills its slot
    function automatic ksw_pkg::data_t extract_min();
        int             span;
        int             best;
        ksw_pkg::data_t v;
        span = (fill_cnt < search_limit()) ? fill_cnt : search_limit();
        best = 0;
        for (int i = 1; i < span; i++)
        begin
            if (window_q[i] < window_q[best])
                best = i;
        end
        v = window_q[best];
        window_q[best] = window_q[0];
        for (int i = 1; i < fill_cnt; i++)
            window_q[i-1] = window_q[i];
        fill_cnt--;
        return v;
    endfunction

    // Enter one word and queue the sorted words it releases
    task automatic sort_word(input ksw_pkg::data_t v, input logic is_last);
        sorted_word_t w;
        if (fill_cnt < ksw_pkg::WIN_DEPTH)
        begin
            window_q[fill_cnt] = v;
            fill_cnt++;
        end
        if (is_last)
        begin
            while (fill_cnt > 0)
            begin
                w.value      = extract_min();
                w.final_word = (fill_cnt == 0);
                expected_words.push_back(w);
            end
        end
        else
        begin
            while (fill_cnt > 0 && fill_cnt >= search_limit())
            begin
                w.value      = extract_min();
                w.final_word = 1'b0;
                expected_words.push_back(w);
            end
        end
    endtask

    // Track config, predict on accepted input, compare on accepted output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt   = 0;
            disp_q     = ksw_pkg::DISP_RESET;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                disp_q = cfg_data;
            if (s_tvalid && s_tready)
                sort_word(ksw_pkg::data_t'(s_tdata), s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected word value=%0d last=%b",
                                 $realtime, $signed(m_tdata), m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.final_word)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: mismatch value exp=%0d got=%0d, last exp=%b got=%b",
                                     $realtime, want.value, $signed(m_tdata),
                                     want.final_word, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: verif/tb_k_sorted_window_sorter_top.sv
module tb_k_sorted_window_sorter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 130;
    localparam int CALM_TAIL     = 30;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    logic        s_took    = 1'b0;
    logic        cfg_took  = 1'b0;
    logic        idle_en   = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [3:0]  disp_now  = ksw_pkg::DISP_RESET;

    always #5 clk = ~clk;

    k_sorted_window_sorter_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    ksw_sort_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Record handshakes so the driver can act on them at the falling edge
    always @(posedge clk)
    begin
        s_took   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // Abort when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stall the output side in short random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            m_tready = 1'b1;
    end

    task automatic write_disp(input logic [3:0] k);
        cfg_data  = k;
        cfg_valid = 1'b1;
        do @(negedge clk); while (!cfg_took);
        cfg_valid = 1'b0;
        disp_now  = k;
    endtask

    task automatic send_word(input ksw_pkg::data_t v, input logic is_last);
        // Insert a random gap before the word
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tdata  = v;
        s_tlast  = is_last;
        s_tvalid = 1'b1;
        do @(negedge clk); while (!s_took);
        s_tvalid = 1'b0;
    endtask

    // Hold the sender until every sorted word is out and the block is idle
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        ksw_pkg::data_t run_words [$];
        ksw_pkg::data_t acc;
        ksw_pkg::data_t tmp;
        int    n;
        int    mode;
        int    j;
        int    pick;
        int    word_count;
        logic  broken;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset displacement: extremes of the value range
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-32'sd1, 1'b1);
        wait_idle();

        // Zero displacement: every word passes straight through
        write_disp(4'd0);
        send_word(32'sd5, 1'b0);
        send_word(-32'sd5, 1'b1);
        send_word(32'sd1, 1'b1);
        wait_idle();

        // Widest window: the last word releases a full drain
        write_disp(4'd15);
        for (int i = 0; i < ksw_pkg::WIN_DEPTH; i++)
            send_word(ksw_pkg::data_t'(((i * 7) % 16) - 8), i == ksw_pkg::WIN_DEPTH - 1);
        wait_idle();

        // Lower the displacement with words waiting, then drain
        write_disp(4'd5);
        send_word(32'sd3, 1'b0);
        send_word(32'sd3, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd3, 1'b0);
        wait_idle();
        write_disp(4'd0);
        send_word(32'sd2, 1'b1);
        wait_idle();
        write_disp(4'd2);

        // Random runs, mostly nearly sorted
        idle_en    = 1'b1;
        word_count = 0;
        while (word_count < RANDOM_WORDS)
        begin
            if (word_count > RANDOM_WORDS - CALM_TAIL)
                idle_en = 1'b0;
            else if ($urandom_range(0, 7) == 0)
                idle_en = ~idle_en;

            // Change the displacement between runs, sometimes mid-sequence
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                pick = $urandom_range(0, 3);
                write_disp(pick == 0 ? 4'd0 : pick == 1 ? 4'd15
                                     : 4'($urandom_range(0, 15)));
            end

            n      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 20);
            mode   = $urandom_range(0, 9);
            broken = ($urandom_range(0, 5) == 0);
            acc    = $urandom;
            run_words.delete();
            for (int i = 0; i < n; i++)
            begin
                if (mode <= 5)
                begin
                    acc = acc + ksw_pkg::data_t'($urandom_range(0, 1 << $urandom_range(0, 20)));
                    run_words.push_back(acc);
                end
                else if (mode <= 7)
                    run_words.push_back(ksw_pkg::data_t'($urandom_range(0, 7)) - 4);
                else
                    run_words.push_back(ksw_pkg::data_t'($urandom));
            end

            // Scramble a sorted run locally, swapping each word with one at most the displacement ahead
            if (mode <= 5)
            begin
                for (int i = 0; i < n; i++)
                begin
                    j = i + $urandom_range(0, int'(disp_now));
                    if (j < n)
                    begin
                        tmp          = run_words[i];
                        run_words[i] = run_words[j];
                        run_words[j] = tmp;
                    end
                end
            end

            for (int i = 0; i < n; i++)
            begin
                send_word(run_words[i], (i == n - 1) && !broken);
                word_count++;
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
